// ===== sv/button_debounce_event_fifo_defines.svh =====
// Assertion macros for the button debounce event queue.
// Included by bdef_merge, the RTL file that carries concurrent checks; needs nothing else.
`ifndef BUTTON_DEBOUNCE_EVENT_FIFO_DEFINES_SVH
`define BUTTON_DEBOUNCE_EVENT_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BDEF_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("bdef check failed");

// Next-cycle implication, disabled while reset is asserted
`define BDEF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("bdef check failed");

`endif

// ===== sv/bdef_pkg.sv =====
// Shared types, codes and reset constants for the button debounce event queue.
// No dependencies; imported by the lane, merge and top modules of the block.
`default_nettype none

package bdef_pkg;

    // Fixed field widths
    localparam int CODE_W  = 4;
    localparam int PIN_W   = 4;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 8;
    localparam int INDEX_W = 3;

    // Parameter defaults
    localparam int DEFAULT_BUTTONS     = 4;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Counter constants
    localparam logic [COUNT_W-1:0] FILTER_RESET_COUNT = 8'd25;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hff;

    // Register reset values
    localparam logic [COUNT_W-1:0] FILTER_TICKS_RESET  = 8'd50;
    localparam logic [COUNT_W-1:0] HOLD_PERIODS_RESET  = 8'd10;
    localparam logic               REPEAT_ENABLE_RESET = 1'b0;
    localparam logic [PIN_W-1:0]   ACTIVE_LEVELS_RESET = 4'h0;
    localparam logic [PIN_W-1:0]   BUTTON_ENABLE_RESET = 4'h3;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_FILTER_TICKS  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_HOLD_PERIODS  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_REPEAT_ENABLE = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ACTIVE_LEVELS = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BUTTON_ENABLE = 3'd4;

    // Command actions
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Event offsets added to button*3
    localparam logic [CODE_W-1:0] EV_PRESS   = 4'd1;
    localparam logic [CODE_W-1:0] EV_LONG    = 4'd2;
    localparam logic [CODE_W-1:0] EV_RELEASE = 4'd3;
    localparam logic [CODE_W-1:0] EV_NONE    = 4'd0;

    typedef struct packed {
        logic             action;
        logic [PIN_W-1:0] pin_levels;
    } bdef_cmd_t;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              queue_empty;
    } bdef_result_t;

    // Timing settings seen by every lane
    typedef struct packed {
        logic [COUNT_W-1:0] filter_ticks;
        logic [COUNT_W-1:0] hold_periods;
        logic               repeat_enable;
    } bdef_cfg_t;

    // One queued event candidate from a lane
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } bdef_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_READ
    } bdef_state_t;

endpackage

`default_nettype wire

// ===== sv/bdef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bdef_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bdef_lane.sv =====
// One button lane: pressed flag, filter and hold counters, event candidates.
// Depends on bdef_pkg.
`default_nettype none

module bdef_lane #(
    parameter int LANE = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic                   pin_level,
    input  wire logic                   press_level,
    input  wire logic                   enable,
    input  wire bdef_pkg::bdef_cfg_t    cfg,
    output bdef_pkg::bdef_event_t [1:0] events
);
    import bdef_pkg::*;

    localparam logic [CODE_W-1:0] BASE = CODE_W'(LANE * 3);

    logic               pressed_reg, pressed_next;
    logic [COUNT_W-1:0] filt_reg, filt_next;
    logic [COUNT_W-1:0] hold_reg, hold_next;

    logic               down;
    logic [COUNT_W-1:0] filt_inc;
    logic [COUNT_W-1:0] hold_inc;
    logic               period_done;

    assign down        = enable && (pin_level == press_level);
    assign filt_inc    = (filt_reg < COUNT_MAX) ? filt_reg + 1'b1 : COUNT_MAX;
    assign hold_inc    = (hold_reg < COUNT_MAX) ? hold_reg + 1'b1 : COUNT_MAX;
    assign period_done = (filt_inc >= cfg.filter_ticks);

    // Work out next lane state and the two event slots for this tick
    always_comb
    begin
        pressed_next     = pressed_reg;
        filt_next        = filt_inc;
        hold_next        = hold_reg;
        events[0].valid  = 1'b0;
        events[0].code   = BASE + EV_PRESS;
        events[1].valid  = 1'b0;
        events[1].code   = BASE + EV_PRESS;
        if (down)
        begin
            if (!pressed_reg)
            begin
                pressed_next = 1'b1;
                hold_next    = '0;
                filt_next    = '0;
            end
            else if (period_done)
            begin
                filt_next       = '0;
                hold_next       = hold_inc;
                events[0].valid = (hold_reg == '0);
                if (cfg.hold_periods != '0 && hold_inc == cfg.hold_periods
                    && hold_inc != hold_reg)
                begin
                    events[1].valid = 1'b1;
                    events[1].code  = BASE + EV_LONG;
                end
                else if (cfg.repeat_enable && cfg.hold_periods != '0
                         && hold_inc > cfg.hold_periods)
                begin
                    events[1].valid = 1'b1;
                end
            end
        end
        else if (pressed_reg && period_done)
        begin
            pressed_next    = 1'b0;
            hold_next       = '0;
            filt_next       = '0;
            events[0].valid = 1'b1;
            events[0].code  = BASE + EV_RELEASE;
        end
    end

    // Advance lane state on each accepted scan tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            filt_reg    <= FILTER_RESET_COUNT;
            hold_reg    <= '0;
        end
        else if (step)
        begin
            pressed_reg <= pressed_next;
            filt_reg    <= filt_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bdef_merge.sv =====
// Merge stage: collects lane events, pushes one per cycle into the ring queue
// (dropped if full), serves reads. Depends on bdef_pkg, bdef_ram, macro header.
`default_nettype none
`include "button_debounce_event_fifo_defines.svh"

module bdef_merge #(
    parameter int BUTTONS     = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 load,
    input  wire bdef_pkg::bdef_event_t [2*BUTTONS-1:0] events,
    input  wire logic                                 read_req,
    output logic                                      busy,
    output logic                                      done,
    output bdef_pkg::bdef_result_t                    result
);
    import bdef_pkg::*;

    localparam int SLOTS = 2 * BUTTONS;
    localparam int SEL_W = $clog2(SLOTS);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    bdef_state_t state_reg, state_next;

    logic [SLOTS-1:0]  pend_valid_reg, pend_valid_next;
    logic [CODE_W-1:0] pend_code_reg [SLOTS];
    logic [PTR_W-1:0]  wp_reg, wp_inc;
    logic [PTR_W-1:0]  rp_reg, rp_inc;
    logic              empty_reg;

    logic [SLOTS-1:0]  new_valid;
    logic [SLOTS-1:0]  pend_after;
    logic [SEL_W-1:0]  sel;
    logic              full;
    logic              queue_is_empty;
    logic              wr_en;
    logic [CODE_W-1:0] rd_data;

    // Gather the valid bits of the incoming events
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            new_valid[i] = events[i].valid;
        end
    end

    // Pick the lowest pending slot: lane order, first event before second
    always_comb
    begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pend_valid_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
        pend_after      = pend_valid_reg;
        pend_after[sel] = 1'b0;
    end

    assign wp_inc         = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc         = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign full           = (wp_inc == rp_reg);
    assign queue_is_empty = (rp_reg == wp_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load && (new_valid != '0))
                begin
                    state_next = ST_DRAIN;
                end
                else if (read_req)
                begin
                    state_next = ST_READ;
                end
            end
            ST_DRAIN:
            begin
                if (pend_after == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        busy  = 1'b0;
        wr_en = 1'b0;
        done  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_DRAIN:
            begin
                busy  = 1'b1;
                wr_en = !full;
            end
            ST_READ:
            begin
                busy = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Load fresh events, or drop the slot just drained
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load)
        begin
            pend_valid_next = new_valid;
        end
        else if (state_reg == ST_DRAIN)
        begin
            pend_valid_next = pend_after;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= '0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            empty_reg      <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_en)
            begin
                wp_reg <= wp_inc;
            end
            if (read_req)
            begin
                empty_reg <= queue_is_empty;
                if (!queue_is_empty)
                begin
                    rp_reg <= rp_inc;
                end
            end
        end
    end

    // Hold event codes for the drain
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                pend_code_reg[i] <= events[i].code;
            end
        end
    end

    bdef_ram #(
        .WIDTH (CODE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (pend_code_reg[sel]),
        .rd_en   (read_req),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    assign result.event_code  = empty_reg ? EV_NONE : rd_data;
    assign result.queue_empty = empty_reg;

    // Checks
    `BDEF_ASSERT_NEXT(a_read_gives_result, clk, rst_n, read_req, done)
    `BDEF_ASSERT_NOW(a_empty_reads_zero, clk, rst_n, done && result.queue_empty, result.event_code == EV_NONE)
    `BDEF_ASSERT_NOW(a_drain_has_work, clk, rst_n, state_reg == ST_DRAIN, pend_valid_reg != '0)
    `BDEF_ASSERT_NOW(a_no_push_when_full, clk, rst_n, wr_en, wp_inc != rp_reg)

endmodule

`default_nettype wire

// ===== sv/button_debounce_event_fifo.sv =====
// Top level of the button debounce event queue: registers, lanes, merge stage.
// Depends on bdef_pkg, bdef_lane and bdef_merge.
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------
//   command  | start / busy      | cmd.action, cmd.pin_levels
//   result   | done (one cycle)  | result.event_code, result.queue_empty
//   config   | cfg_we            | cfg_index, cfg_data
//
// A scan tick is accepted while busy is low; the events it raises, 0 to
// 2*BUTTONS of them, then go one after another through the single queue write
// port, and busy stays high while they drain. A read raises busy and done
// with the item in the cycle after it is accepted (registered RAM read).
// Reset clears lanes, pointers and registers at once; the event store needs no
// clearing. The receiver cannot stall: a result is valid for its done cycle only.
`default_nettype none

module button_debounce_event_fifo #(
    parameter int BUTTONS     = bdef_pkg::DEFAULT_BUTTONS,
    parameter int QUEUE_DEPTH = bdef_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire bdef_pkg::bdef_cmd_t           cmd,
    output logic                               done,
    output bdef_pkg::bdef_result_t             result,
    input  wire logic                          cfg_we,
    input  wire logic [bdef_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [bdef_pkg::CFG_W-1:0]    cfg_data
);
    import bdef_pkg::*;

    logic [COUNT_W-1:0] filter_ticks_reg;
    logic [COUNT_W-1:0] hold_periods_reg;
    logic               repeat_enable_reg;
    logic [PIN_W-1:0]   active_levels_reg;
    logic [PIN_W-1:0]   button_enable_reg;

    bdef_cfg_t                   lane_cfg;
    bdef_event_t [2*BUTTONS-1:0] lane_events;
    logic                        accept;
    logic                        scan;
    logic                        read_req;

    assign accept   = start && !busy;
    assign scan     = accept && (cmd.action == ACT_SCAN);
    assign read_req = accept && (cmd.action == ACT_READ);

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_ticks_reg  <= FILTER_TICKS_RESET;
            hold_periods_reg  <= HOLD_PERIODS_RESET;
            repeat_enable_reg <= REPEAT_ENABLE_RESET;
            active_levels_reg <= ACTIVE_LEVELS_RESET;
            button_enable_reg <= BUTTON_ENABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_TICKS:  filter_ticks_reg  <= cfg_data;
                REG_HOLD_PERIODS:  hold_periods_reg  <= cfg_data;
                REG_REPEAT_ENABLE: repeat_enable_reg <= cfg_data[0];
                REG_ACTIVE_LEVELS: active_levels_reg <= cfg_data[PIN_W-1:0];
                REG_BUTTON_ENABLE: button_enable_reg <= cfg_data[PIN_W-1:0];
                default:           ;
            endcase
        end
    end

    assign lane_cfg.filter_ticks  = filter_ticks_reg;
    assign lane_cfg.hold_periods  = hold_periods_reg;
    assign lane_cfg.repeat_enable = repeat_enable_reg;

    // One lane per button
    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_lane
        bdef_lane #(
            .LANE (b)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (scan),
            .pin_level   (cmd.pin_levels[b]),
            .press_level (active_levels_reg[b]),
            .enable      (button_enable_reg[b]),
            .cfg         (lane_cfg),
            .events      (lane_events[2*b+1:2*b])
        );
    end

    bdef_merge #(
        .BUTTONS     (BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (scan),
        .events   (lane_events),
        .read_req (read_req),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire
